// File: design/polyline_self_intersection_count_assert.svh
// Assertion macros for the polyline self-intersection counter checker.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef POLYLINE_SELF_INTERSECTION_COUNT_ASSERT_SVH
`define POLYLINE_SELF_INTERSECTION_COUNT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PSIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PSIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/psic_pkg.sv
// Shared types and constants for the polyline self-intersection counter.
// No dependencies; imported by every design module and the checker.
package psic_pkg;

	localparam int MAX_POINTS = 256;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = PTR_W + 1;
	localparam int COORD_W    = 20;
	localparam int COUNT_W    = 15;
	localparam int MIN_POINTS = 4;
	localparam int ORIENT_N   = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic                      last_point;
	} point_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] intersection_count;
		logic               overflow;
	} result_t;

	// Orientation test of probe against the line org -> tip
	typedef struct packed {
		logic   issue;
		point_t org;
		point_t tip;
		point_t probe;
	} orient_req_t;

	typedef struct packed {
		logic valid;
		logic pos;
		logic neg;
	} orient_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_ROW_RD,
		S_ROW_CAP,
		S_PAIR_RD,
		S_PAIR_CAP,
		S_BOX,
		S_ORIENT,
		S_WAIT,
		S_EVAL,
		S_NEXT,
		S_DONE
	} state_t;

endpackage

// File: design/psic_store.sv
// Point store: one write port, two registered read ports.
// Depends on psic_pkg for point_t and the store depth.
module psic_store
	import psic_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] waddr,
	input  point_t           wdata,
	input  logic [PTR_W-1:0] raddr0,
	input  logic [PTR_W-1:0] raddr1,
	output point_t           rdata0,
	output point_t           rdata1
);

	point_t mem [MAX_POINTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two read ports, data registered
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: design/psic_orient.sv
// Shared orientation unit: sign of the 2D cross product, three stages.
// Depends on psic_pkg for the request and response structs.
module psic_orient
	import psic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  orient_req_t req,
	output orient_rsp_t rsp
);

	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0] bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic signed [SUM_W-1:0]  diff;
	logic                     pos_s3, neg_s3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= req.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign diff = SUM_W'(p1_s2) - SUM_W'(p2_s2);

	// s1: differences from the origin, s2: products, s3: sign
	always_ff @(posedge clk) begin
		bx_s1  <= DIFF_W'(req.tip.x) - DIFF_W'(req.org.x);
		by_s1  <= DIFF_W'(req.tip.y) - DIFF_W'(req.org.y);
		cx_s1  <= DIFF_W'(req.probe.x) - DIFF_W'(req.org.x);
		cy_s1  <= DIFF_W'(req.probe.y) - DIFF_W'(req.org.y);
		p1_s2  <= PROD_W'(bx_s1) * PROD_W'(cy_s1);
		p2_s2  <= PROD_W'(by_s1) * PROD_W'(cx_s1);
		pos_s3 <= !diff[SUM_W-1] && (diff != '0);
		neg_s3 <= diff[SUM_W-1];
	end

	assign rsp.valid = valid_s3;
	assign rsp.pos   = pos_s3;
	assign rsp.neg   = neg_s3;

endmodule

// File: design/polyline_self_intersection_count.sv
// Polyline self-intersection counter: takes one unmarked point per cycle, busy low.
// After the last point: setup, a store read and capture per row, then per pair a
// read, capture and box test unless skipped, then tests on the 3-stage orientation
// unit, a wait and an evaluation if the boxes meet; then the 1-cycle result strobe.
// The result strobe lasts one cycle and cannot be stalled; busy drops after it.
// Reset (arst_n low) empties the store count and clears the closed-path flag.
module polyline_self_intersection_count
	import psic_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  point_in_t point,
	output logic      done,
	output result_t   result,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, i_q, j_q;
	logic               ovf_q, closed_q;
	logic [1:0]         iss_q;
	logic [2:0]         rcv_q;
	logic [COUNT_W-1:0] total_q;
	point_t             a_q, b_q, c_q, d_q;
	logic [ORIENT_N-1:0] pos_q, neg_q;

	logic [CNT_W-1:0] segs, j_nx, i_nx3, rsel, rsel_nx;
	logic             we, skip_pair, box_hit, cross_hit;
	point_t           wpt, rd0, rd1;
	orient_req_t      oreq;
	orient_rsp_t      orsp;

	psic_store u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (count_q[PTR_W-1:0]),
		.wdata  (wpt),
		.raddr0 (rsel[PTR_W-1:0]),
		.raddr1 (rsel_nx[PTR_W-1:0]),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	psic_orient u_orient (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (oreq),
		.rsp    (orsp)
	);

	// loop bounds and store access
	assign segs    = count_q - CNT_W'(1);
	assign j_nx    = j_q + CNT_W'(1);
	assign i_nx3   = i_q + CNT_W'(3);
	assign rsel    = (state_q == S_ROW_RD) ? i_q : j_q;
	assign rsel_nx = rsel + CNT_W'(1);
	assign we      = (state_q == S_IDLE) && start && (count_q != CNT_W'(MAX_POINTS));
	assign wpt.x   = point.x_coord;
	assign wpt.y   = point.y_coord;

	// first and last segment are not compared in closed-path mode
	assign skip_pair = closed_q && (i_q == '0) && (j_nx == segs);

	// bounding-box overlap of segment a-b and segment c-d
	always_comb begin
		logic signed [COORD_W-1:0] pxl, pxh, pyl, pyh, qxl, qxh, qyl, qyh;
		pxl = (a_q.x < b_q.x) ? a_q.x : b_q.x;
		pxh = (a_q.x < b_q.x) ? b_q.x : a_q.x;
		pyl = (a_q.y < b_q.y) ? a_q.y : b_q.y;
		pyh = (a_q.y < b_q.y) ? b_q.y : a_q.y;
		qxl = (c_q.x < d_q.x) ? c_q.x : d_q.x;
		qxh = (c_q.x < d_q.x) ? d_q.x : c_q.x;
		qyl = (c_q.y < d_q.y) ? c_q.y : d_q.y;
		qyh = (c_q.y < d_q.y) ? d_q.y : c_q.y;
		box_hit = (pxl <= qxh) && (qxl <= pxh) && (pyl <= qyh) && (qyl <= pyh);
	end

	// strict opposite signs on both sides
	assign cross_hit = ((pos_q[0] && neg_q[1]) || (neg_q[0] && pos_q[1])) &&
	                   ((pos_q[2] && neg_q[3]) || (neg_q[2] && pos_q[3]));

	// orientation requests: c and d against a-b, then a and b against c-d
	always_comb begin
		oreq.issue = (state_q == S_ORIENT);
		oreq.org   = a_q;
		oreq.tip   = b_q;
		oreq.probe = c_q;
		case (iss_q)
			2'd0: begin
				oreq.probe = c_q;
			end
			2'd1: begin
				oreq.probe = d_q;
			end
			2'd2: begin
				oreq.org   = c_q;
				oreq.tip   = d_q;
				oreq.probe = a_q;
			end
			default: begin
				oreq.org   = c_q;
				oreq.tip   = d_q;
				oreq.probe = b_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && point.last_point) state_d = S_SETUP;
			end
			S_SETUP: begin
				state_d = (count_q < CNT_W'(MIN_POINTS)) ? S_DONE : S_ROW_RD;
			end
			S_ROW_RD:   state_d = S_ROW_CAP;
			S_ROW_CAP:  state_d = S_PAIR_RD;
			S_PAIR_RD:  state_d = skip_pair ? S_NEXT : S_PAIR_CAP;
			S_PAIR_CAP: state_d = S_BOX;
			S_BOX:      state_d = box_hit ? S_ORIENT : S_NEXT;
			S_ORIENT: begin
				if (iss_q == 2'(ORIENT_N - 1)) state_d = S_WAIT;
			end
			S_WAIT: begin
				if (rcv_q == 3'(ORIENT_N)) state_d = S_EVAL;
			end
			S_EVAL: state_d = S_NEXT;
			S_NEXT: begin
				if (j_nx < segs) begin
					state_d = S_PAIR_RD;
				end else if (i_nx3 < segs) begin
					state_d = S_ROW_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			closed_q <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			iss_q    <= '0;
			rcv_q    <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_we) closed_q <= cfg_wdata;
			if (we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == S_IDLE && start) begin
				ovf_q <= 1'b1;
			end
			if (state_q == S_SETUP) begin
				i_q     <= '0;
				j_q     <= CNT_W'(2);
				total_q <= '0;
			end
			if (state_q == S_BOX) begin
				iss_q <= '0;
				rcv_q <= '0;
			end
			if (state_q == S_ORIENT) iss_q <= iss_q + 2'd1;
			if (orsp.valid) rcv_q <= rcv_q + 3'd1;
			if (state_q == S_EVAL && cross_hit && total_q != COUNT_MAX) begin
				total_q <= total_q + COUNT_W'(1);
			end
			if (state_q == S_NEXT) begin
				if (j_nx < segs) begin
					j_q <= j_nx;
				end else begin
					i_q <= i_q + CNT_W'(1);
					j_q <= i_nx3;
				end
			end
			if (state_q == S_DONE) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// segment end points and collected signs
	always_ff @(posedge clk) begin
		if (state_q == S_ROW_CAP) begin
			a_q <= rd0;
			b_q <= rd1;
		end
		if (state_q == S_PAIR_CAP) begin
			c_q <= rd0;
			d_q <= rd1;
		end
		if (orsp.valid) begin
			pos_q[rcv_q[1:0]] <= orsp.pos;
			neg_q[rcv_q[1:0]] <= orsp.neg;
		end
	end

	assign busy                      = (state_q != S_IDLE);
	assign done                      = (state_q == S_DONE);
	assign result.intersection_count = total_q;
	assign result.overflow           = ovf_q;

endmodule

// File: design/psic_chk.sv
// Port-level checker for the polyline self-intersection counter, with bind.
// Depends on psic_pkg and polyline_self_intersection_count_assert.svh.
`include "polyline_self_intersection_count_assert.svh"

module psic_chk
	import psic_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input point_in_t point,
	input logic      done
);

	// the result strobe only shows while the count is still running
	`PSIC_ASSERT_NOW(a_done_busy, done, busy, "result strobe while not busy")

	// a transfer with the last-point mark starts the count
	`PSIC_ASSERT_NEXT(a_last_busy, start && !busy && point.last_point, busy,
		"last point did not start the count")

	// an unmarked point is stored without leaving the block busy
	`PSIC_ASSERT_NEXT(a_point_free, start && !busy && !point.last_point, !busy,
		"unmarked point left the block busy")

	// one strobe per polyline
	`PSIC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held over two cycles")

	// busy ends only with a delivered result
	`PSIC_ASSERT_NOW(a_busy_end, $fell(busy), $past(done), "busy fell without a result")

endmodule

bind polyline_self_intersection_count psic_chk u_psic_chk (.*);

// File: tb/tb_polyline_self_intersection_count.sv
// Testbench for the polyline self-intersection counter: drives whole polylines
// through the start/busy port and checks every counted result against a predictor.
// Depends on psic_pkg and the polyline_self_intersection_count top level.
module tb_polyline_self_intersection_count;
	import psic_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam int COORD_LO     = -(1 << (COORD_W - 1));
	localparam int COORD_HI     = (1 << (COORD_W - 1)) - 1;
	localparam int ITEM_TARGET  = 1750;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int RAMP_STEP    = 4000;

	// Point generators: full range, tiny grid (collinear and touching), mid range,
	// and a strictly rising x ramp whose non-adjacent segments never share an x span
	typedef enum {SHAPE_WIDE, SHAPE_GRID, SHAPE_NEAR, SHAPE_RAMP} shape_e;

	// Crossing-count predictor and store of expected results
	class crossing_scoreboard;
		point_t  pts[MAX_POINTS];
		int      n_stored;
		bit      overflowed;
		bit      path_closed;
		result_t expected_q[$];
		int      errors;

		function new();
			n_stored    = 0;
			overflowed  = 1'b0;
			path_closed = 1'b0;
			errors      = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		function void set_closed(bit v);
			path_closed = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Sign of the turn from a->b towards c
		function int turn_sign(point_t a, point_t b, point_t c);
			logic signed [COORD_W:0]     bx, by, cx, cy;
			logic signed [2*COORD_W+2:0] v;
			bx = $signed(b.x) - $signed(a.x);
			by = $signed(b.y) - $signed(a.y);
			cx = $signed(c.x) - $signed(a.x);
			cy = $signed(c.y) - $signed(a.y);
			v  = bx * cy - by * cx;
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		function bit spans_meet(coord_t p0, coord_t p1, coord_t q0, coord_t q1);
			coord_t plo, phi, qlo, qhi, lo, hi;
			plo = (p0 < p1) ? p0 : p1;
			phi = (p0 < p1) ? p1 : p0;
			qlo = (q0 < q1) ? q0 : q1;
			qhi = (q0 < q1) ? q1 : q0;
			lo  = (plo > qlo) ? plo : qlo;
			hi  = (phi < qhi) ? phi : qhi;
			return lo <= hi;
		endfunction

		// Proper crossing: boxes overlap and both pairs of end points strictly split
		function bit segments_cross(int ia, int ib, int ic, int id);
			point_t a, b, c, d;
			a = pts[ia];
			b = pts[ib];
			c = pts[ic];
			d = pts[id];
			if (!spans_meet(a.x, b.x, c.x, d.x) || !spans_meet(a.y, b.y, c.y, d.y))
				return 1'b0;
			return (turn_sign(a, b, c) * turn_sign(a, b, d) < 0) &&
				(turn_sign(c, d, a) * turn_sign(c, d, b) < 0);
		endfunction

		function logic [COUNT_W-1:0] count_crossings();
			int                 segs;
			logic [COUNT_W-1:0] total;
			total = '0;
			if (n_stored < MIN_POINTS)
				return '0;
			segs = n_stored - 1;
			for (int i = 0; i < segs; i++) begin
				for (int j = i + 2; j < segs; j++) begin
					// closed path: first and last segment share the start point
					if (path_closed && i == 0 && j + 1 == segs)
						continue;
					if (segments_cross(i, i + 1, j, j + 1) && total != COUNT_MAX)
						total++;
				end
			end
			return total;
		endfunction

		function void note_point(point_in_t p);
			result_t r;
			if (n_stored < MAX_POINTS) begin
				pts[n_stored].x = p.x_coord;
				pts[n_stored].y = p.y_coord;
				n_stored++;
			end else begin
				overflowed = 1'b1;
			end
			if (p.last_point) begin
				r.intersection_count = count_crossings();
				r.overflow           = overflowed;
				expected_q = {expected_q, r};
				n_stored   = 0;
				overflowed = 1'b0;
			end
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result: count %0d overflow %0b",
					got.intersection_count, got.overflow));
				return;
			end
			want = expected_q.pop_front();
			if (got.intersection_count !== want.intersection_count)
				report($sformatf("intersection_count %0d, expected %0d",
					got.intersection_count, want.intersection_count));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	point_in_t point;
	logic      done;
	result_t   result;
	logic      cfg_we;
	logic      cfg_wdata;

	crossing_scoreboard sb = new();
	int unsigned        cycle_count = 0;
	int                 items_sent;
	bit                 idle_on;

	polyline_self_intersection_count u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result strobe cannot be held off: check every transfer as it appears
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic coord_t pick_coord(shape_e s);
		int r;
		case (s)
			SHAPE_GRID: begin
				return coord_t'(int'($urandom_range(16, 0)) - 8);
			end
			SHAPE_NEAR: begin
				return coord_t'(int'($urandom_range(4000, 0)) - 2000);
			end
			default: begin
				r = $urandom_range(9, 0);
				if (r == 0)
					return coord_t'(COORD_LO);
				if (r == 1)
					return coord_t'(COORD_HI);
				return coord_t'($urandom);
			end
		endcase
	endfunction

	// One point transfer; start is left high so back-to-back points need no gap
	task automatic send_point(int x, int y, bit last);
		point_in_t p;
		int        gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		p.x_coord    = coord_t'(x);
		p.y_coord    = coord_t'(y);
		p.last_point = last;
		@(negedge clk);
		start <= 1'b1;
		point <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_point(p);
		items_sent++;
	endtask

	// Register write once the block has drained and gone idle
	task automatic write_closed(bit v);
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (3) @(negedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_closed(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_polyline(int n, shape_e s, bit close_path);
		int x, y, x0, y0;
		for (int k = 0; k < n; k++) begin
			if (s == SHAPE_RAMP) begin
				x = COORD_LO + k * RAMP_STEP + int'($urandom_range(2000, 0));
				y = int'(pick_coord(SHAPE_WIDE));
			end else begin
				x = int'(pick_coord(s));
				y = int'(pick_coord(s));
			end
			if (k == 0) begin
				x0 = x;
				y0 = y;
			end else if (close_path && k == n - 1) begin
				x = x0;
				y = y0;
			end
			send_point(x, y, k == n - 1);
		end
	endtask

	initial begin
		int     poly;
		int     r;
		int     len;
		shape_e shape;

		arst_n     = 1'b0;
		start      = 1'b0;
		point      = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		items_sent = 0;
		idle_on    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: lone points and short polylines give zero
		send_point(0, 0, 1'b1);
		send_point(COORD_HI, COORD_LO, 1'b1);
		send_point(COORD_LO, COORD_LO, 1'b0);
		send_point(COORD_HI, COORD_HI, 1'b0);
		send_point(-1, 0, 1'b1);
		// bow-tie across the full coordinate range
		send_point(COORD_LO, COORD_LO, 1'b0);
		send_point(COORD_HI, COORD_HI, 1'b0);
		send_point(COORD_HI, COORD_LO, 1'b0);
		send_point(COORD_LO, COORD_HI, 1'b1);
		// closed path: the crossing first/last pair is skipped
		write_closed(1'b1);
		send_point(0, 0, 1'b0);
		send_point(10, 10, 1'b0);
		send_point(10, 0, 1'b0);
		send_point(0, 10, 1'b1);
		write_closed(1'b0);
		// touching end point and collinear overlap are not crossings
		send_point(0, 0, 1'b0);
		send_point(10, 0, 1'b0);
		send_point(10, 5, 1'b0);
		send_point(5, 0, 1'b0);
		send_point(15, 0, 1'b1);
		// small bow-tie around the origin, open path
		send_point(-10, -10, 1'b0);
		send_point(10, 10, 1'b0);
		send_point(10, -10, 1'b0);
		send_point(-10, 10, 1'b1);

		// Random polylines, with one exactly full store and one overflowing it
		poly = 0;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(7, 0) == 0)
				write_closed(1'($urandom_range(1, 0)));
			idle_on = ($urandom_range(3, 0) != 0);
			if (poly == 8) begin
				send_polyline(MAX_POINTS, SHAPE_RAMP, 1'b0);
			end else if (poly == 30) begin
				send_polyline(MAX_POINTS + 2, SHAPE_RAMP, 1'b0);
			end else begin
				r = $urandom_range(99, 0);
				if (r < 10)
					len = $urandom_range(3, 1);
				else if (r < 85)
					len = $urandom_range(16, 4);
				else
					len = $urandom_range(48, 17);
				shape = shape_e'($urandom_range(3, 0));
				send_polyline(len, shape, $urandom_range(3, 0) == 0);
			end
			poly++;
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain outstanding counts, then watch for stray strobes
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
